// ===== rtl/core/fcva_pkg.sv =====
// Shared types and codes for the Fp4 cyclic vector ALU.
package fcva_pkg;

	localparam int FIELD_W = 62;
	localparam int N_COMP  = 4;
	localparam int N_LANES = 9;
	localparam int MERGE_STAGES = 6;
	localparam int PREP_STAGES  = 2;

	localparam logic [2:0] MODE_ADD  = 3'd0;
	localparam logic [2:0] MODE_SUB  = 3'd1;
	localparam logic [2:0] MODE_MUL  = 3'd2;
	localparam logic [2:0] MODE_SQR  = 3'd3;
	localparam logic [2:0] MODE_FROB = 3'd4;
	localparam logic [2:0] MODE_NEG  = 3'd5;

	localparam logic REG_MODULUS = 1'b0;
	localparam logic [FIELD_W-1:0] MODULUS_RESET = 62'd7;

	typedef struct packed {
		logic [2:0]         mode;
		logic [FIELD_W-1:0] a_comp0;
		logic [FIELD_W-1:0] a_comp1;
		logic [FIELD_W-1:0] a_comp2;
		logic [FIELD_W-1:0] a_comp3;
		logic [FIELD_W-1:0] b_comp0;
		logic [FIELD_W-1:0] b_comp1;
		logic [FIELD_W-1:0] b_comp2;
		logic [FIELD_W-1:0] b_comp3;
	} fcva_in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] r_comp0;
		logic [FIELD_W-1:0] r_comp1;
		logic [FIELD_W-1:0] r_comp2;
		logic [FIELD_W-1:0] r_comp3;
	} fcva_out_t;

endpackage

// ===== rtl/core/fp4_cyclic_vector_alu.sv =====
// Top level: Fp4 cyclic vector ALU with APB modulus register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  in       | in_valid / in_ready  | in_data  (fcva_in_t: mode, a, b)
//  out      | out_valid / out_ready| out_data (fcva_out_t: r_comp0..3)
//  cfg      | APB psel/penable     | paddr, pwdata, prdata (modulus)
//
// One item per cycle while the skid register is empty. Between the input
// transfer and out_valid lie ELEM_WIDTH remainder stages, 2 prep stages,
// ELEM_WIDTH multiplier stages (one bit each), 6 merge stages, output reg.
// Reset clears valid bits and sets the modulus to 7; no clearing pass.
// A stalled output parks one extra result in a skid register; in_ready
// drops only while that skid register is full, and the whole pipe freezes.
module fp4_cyclic_vector_alu
	import fcva_pkg::*;
#(
	parameter int ELEM_WIDTH = 62
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  fcva_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output fcva_out_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int W = ELEM_WIDTH;
	localparam int DEPTH = 2*W + PREP_STAGES + MERGE_STAGES;

	// ---- config register ----
	logic [W-1:0] modulus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET[W-1:0];
		end else if (psel && penable && pwrite && pready && (paddr[3] == REG_MODULUS)) begin
			modulus_q <= pwdata[W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_MODULUS) ? 64'(modulus_q) : '0;

	// ---- pipeline control ----
	logic             en;
	logic [DEPTH-1:0] vld_q;
	logic             skid_v_q;
	logic             out_v_q;
	logic             exit_v;

	assign en       = !skid_v_q;
	assign in_ready = en;
	assign exit_v   = en && vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	// ---- remainder lanes: operands mod p ----
	logic [N_COMP-1:0][W-1:0] a_in, b_in, a_red, b_red;

	assign a_in[0] = in_data.a_comp0[W-1:0];
	assign a_in[1] = in_data.a_comp1[W-1:0];
	assign a_in[2] = in_data.a_comp2[W-1:0];
	assign a_in[3] = in_data.a_comp3[W-1:0];
	assign b_in[0] = in_data.b_comp0[W-1:0];
	assign b_in[1] = in_data.b_comp1[W-1:0];
	assign b_in[2] = in_data.b_comp2[W-1:0];
	assign b_in[3] = in_data.b_comp3[W-1:0];

	for (genvar i = 0; i < N_COMP; i++) begin : g_red
		fcva_modred #(.W(W)) u_red_a (
			.clk(clk), .en(en), .p(modulus_q), .x(a_in[i]), .r(a_red[i])
		);
		fcva_modred #(.W(W)) u_red_b (
			.clk(clk), .en(en), .p(modulus_q), .x(b_in[i]), .r(b_red[i])
		);
	end

	// mode rides alongside the remainder stages
	logic [2:0] mode_red_q [W];

	always_ff @(posedge clk) begin
		if (en) begin
			mode_red_q[0] <= in_data.mode;
			for (int j = 1; j < W; j++) begin
				mode_red_q[j] <= mode_red_q[j-1];
			end
		end
	end

	// ---- operand prep ----
	logic [2:0]                 mode_prep;
	logic [N_COMP-1:0][W-1:0]   lin_prep;
	logic [N_LANES-1:0][W-1:0]  lane_x, lane_y, lane_m;

	fcva_prep #(.W(W)) u_prep (
		.clk(clk), .en(en), .p(modulus_q), .mode(mode_red_q[W-1]),
		.a(a_red), .b(b_red),
		.mode_o(mode_prep), .lin_o(lin_prep), .lane_x(lane_x), .lane_y(lane_y)
	);

	// ---- nine multiplier lanes ----
	for (genvar k = 0; k < N_LANES; k++) begin : g_mul
		fcva_modmul #(.W(W)) u_mul (
			.clk(clk), .en(en), .p(modulus_q),
			.x(lane_x[k]), .y(lane_y[k]), .r(lane_m[k])
		);
	end

	// linear result and mode wait out the multiplier depth
	logic [2:0]               mode_mul_q [W];
	logic [N_COMP-1:0][W-1:0] lin_mul_q  [W];

	always_ff @(posedge clk) begin
		if (en) begin
			mode_mul_q[0] <= mode_prep;
			lin_mul_q[0]  <= lin_prep;
			for (int j = 1; j < W; j++) begin
				mode_mul_q[j] <= mode_mul_q[j-1];
				lin_mul_q[j]  <= lin_mul_q[j-1];
			end
		end
	end

	// ---- merge ----
	logic [N_COMP-1:0][W-1:0] res;

	fcva_merge #(.W(W)) u_merge (
		.clk(clk), .en(en), .p(modulus_q), .mode(mode_mul_q[W-1]),
		.lin(lin_mul_q[W-1]), .m(lane_m), .res(res)
	);

	// ---- output register plus skid ----
	fcva_out_t res_pk;
	fcva_out_t out_d_q;
	fcva_out_t skid_d_q;

	assign res_pk.r_comp0 = FIELD_W'(res[0]);
	assign res_pk.r_comp1 = FIELD_W'(res[1]);
	assign res_pk.r_comp2 = FIELD_W'(res[2]);
	assign res_pk.r_comp3 = FIELD_W'(res[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= exit_v;
			end
		end else if (exit_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			out_d_q <= skid_v_q ? skid_d_q : res_pk;
		end else if (exit_v) begin
			skid_d_q <= res_pk;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_d_q;

endmodule

// ===== rtl/core/fcva_modred.sv =====
// Pipelined remainder lane: x mod p, one dividend bit per stage.
module fcva_modred #(
	parameter int W = 62
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] p,
	input  logic [W-1:0] x,
	output logic [W-1:0] r
);

	logic [W-1:0] rem_s   [W];
	logic [W-1:0] bits_s  [W-1];
	logic [W-1:0] rem_nx  [W];
	logic [W-1:0] bits_nx [W-1];

	always_comb begin
		logic [W-1:0] rin;
		logic [W-1:0] bin;
		logic [W:0]   t;
		rin = '0;
		bin = '0;
		t   = '0;
		for (int j = 0; j < W; j++) begin
			if (j == 0) begin
				rin = '0;
				bin = x;
			end else begin
				rin = rem_s[j-1];
				bin = bits_s[j-1];
			end
			t = {rin, bin[W-1]};
			if (t >= {1'b0, p}) begin
				t = t - {1'b0, p};
			end
			rem_nx[j] = t[W-1:0];
			if (j < W-1) begin
				bits_nx[j] = bin << 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < W; j++) begin
				rem_s[j] <= rem_nx[j];
			end
			for (int j = 0; j < W-1; j++) begin
				bits_s[j] <= bits_nx[j];
			end
		end
	end

	assign r = rem_s[W-1];

endmodule

// ===== rtl/core/fcva_modmul.sv =====
// Pipelined modular multiplier lane: double-and-add, one multiplier bit per stage.
module fcva_modmul #(
	parameter int W = 62
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] p,
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	output logic [W-1:0] r
);

	logic [W-1:0] acc_s  [W];
	logic [W-1:0] x_s    [W-1];
	logic [W-1:0] y_s    [W-1];
	logic [W-1:0] acc_nx [W];

	function automatic logic [W-1:0] add_m(input logic [W-1:0] u, input logic [W-1:0] v,
	                                       input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, u} + {1'b0, v};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[W-1:0];
	endfunction

	always_comb begin
		logic [W-1:0] ain;
		logic [W-1:0] xin;
		logic [W-1:0] yin;
		logic [W-1:0] t;
		ain = '0;
		xin = '0;
		yin = '0;
		t   = '0;
		for (int j = 0; j < W; j++) begin
			if (j == 0) begin
				ain = '0;
				xin = x;
				yin = y;
			end else begin
				ain = acc_s[j-1];
				xin = x_s[j-1];
				yin = y_s[j-1];
			end
			t = add_m(ain, ain, p);
			if (yin[W-1]) begin
				t = add_m(t, xin, p);
			end
			acc_nx[j] = t;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < W; j++) begin
				acc_s[j] <= acc_nx[j];
			end
			x_s[0] <= x;
			y_s[0] <= y << 1;
			for (int j = 1; j < W-1; j++) begin
				x_s[j] <= x_s[j-1];
				y_s[j] <= y_s[j-1] << 1;
			end
		end
	end

	assign r = acc_s[W-1];

endmodule

// ===== rtl/core/fcva_prep.sv =====
// Operand preparation: differences, linear ops and multiplier lane operands.
module fcva_prep
	import fcva_pkg::*;
#(
	parameter int W = 62
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [W-1:0]                p,
	input  logic [2:0]                  mode,
	input  logic [N_COMP-1:0][W-1:0]    a,
	input  logic [N_COMP-1:0][W-1:0]    b,
	output logic [2:0]                  mode_o,
	output logic [N_COMP-1:0][W-1:0]    lin_o,
	output logic [N_LANES-1:0][W-1:0]   lane_x,
	output logic [N_LANES-1:0][W-1:0]   lane_y
);

	function automatic logic [W-1:0] add_m(input logic [W-1:0] u, input logic [W-1:0] v,
	                                       input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, u} + {1'b0, v};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] sub_m(input logic [W-1:0] u, input logic [W-1:0] v,
	                                       input logic [W-1:0] m);
		return (u >= v) ? (u - v) : (u + (m - v));
	endfunction

	// stage 1
	logic [2:0]                 mode_s1;
	logic [N_COMP-1:0][W-1:0]   a_s1, b_s1, lin_s1, lin_nx;
	logic [W-1:0]               da02_s1, da13_s1, da01_s1, da23_s1;
	logic [W-1:0]               db02_s1, db13_s1, db01_s1, db23_s1;
	// stage 2
	logic [2:0]                 mode_s2;
	logic [N_COMP-1:0][W-1:0]   lin_s2;
	logic [N_LANES-1:0][W-1:0]  x_s2, y_s2, x_nx, y_nx;

	always_comb begin
		lin_nx = '0;
		case (mode)
			MODE_ADD: begin
				for (int i = 0; i < N_COMP; i++) lin_nx[i] = add_m(a[i], b[i], p);
			end
			MODE_SUB: begin
				for (int i = 0; i < N_COMP; i++) lin_nx[i] = sub_m(a[i], b[i], p);
			end
			MODE_FROB: begin
				lin_nx[0] = a[2];
				lin_nx[1] = a[0];
				lin_nx[2] = a[3];
				lin_nx[3] = a[1];
			end
			MODE_NEG: begin
				for (int i = 0; i < N_COMP; i++) lin_nx[i] = sub_m('0, a[i], p);
			end
			default: lin_nx = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			a_s1    <= a;
			b_s1    <= b;
			lin_s1  <= lin_nx;
			da02_s1 <= sub_m(a[0], a[2], p);
			da13_s1 <= sub_m(a[1], a[3], p);
			da01_s1 <= sub_m(a[0], a[1], p);
			da23_s1 <= sub_m(a[2], a[3], p);
			db02_s1 <= sub_m(b[0], b[2], p);
			db13_s1 <= sub_m(b[1], b[3], p);
			db01_s1 <= sub_m(b[0], b[1], p);
			db23_s1 <= sub_m(b[2], b[3], p);
		end
	end

	// lane map, product: m13 m02 m01 m23 u a0b0 a1b1 a2b2 a3b3
	// lane map, square : h k a2(a0+d02) a0(a1-d01) a3(a2+d23) a1(a3-d13)
	always_comb begin
		x_nx = '0;
		y_nx = '0;
		if (mode_s1 == MODE_SQR) begin
			x_nx[0] = da01_s1; y_nx[0] = da23_s1;
			x_nx[1] = da02_s1; y_nx[1] = da13_s1;
			x_nx[2] = a_s1[2]; y_nx[2] = add_m(a_s1[0], da02_s1, p);
			x_nx[3] = a_s1[0]; y_nx[3] = sub_m(a_s1[1], da01_s1, p);
			x_nx[4] = a_s1[3]; y_nx[4] = add_m(a_s1[2], da23_s1, p);
			x_nx[5] = a_s1[1]; y_nx[5] = sub_m(a_s1[3], da13_s1, p);
		end else begin
			x_nx[0] = da13_s1; y_nx[0] = db13_s1;
			x_nx[1] = da02_s1; y_nx[1] = db02_s1;
			x_nx[2] = da01_s1; y_nx[2] = db01_s1;
			x_nx[3] = da23_s1; y_nx[3] = db23_s1;
			x_nx[4] = add_m(da02_s1, da13_s1, p);
			y_nx[4] = add_m(db02_s1, db13_s1, p);
			for (int i = 0; i < N_COMP; i++) begin
				x_nx[5+i] = a_s1[i];
				y_nx[5+i] = b_s1[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			lin_s2  <= lin_s1;
			x_s2    <= x_nx;
			y_s2    <= y_nx;
		end
	end

	assign mode_o = mode_s2;
	assign lin_o  = lin_s2;
	assign lane_x = x_s2;
	assign lane_y = y_s2;

endmodule

// ===== rtl/core/fcva_merge.sv =====
// Merge stages: combine nine lane products or pass the linear result.
module fcva_merge
	import fcva_pkg::*;
#(
	parameter int W = 62
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [W-1:0]               p,
	input  logic [2:0]                 mode,
	input  logic [N_COMP-1:0][W-1:0]   lin,
	input  logic [N_LANES-1:0][W-1:0]  m,
	output logic [N_COMP-1:0][W-1:0]   res
);

	function automatic logic [W-1:0] add_m(input logic [W-1:0] u, input logic [W-1:0] v,
	                                       input logic [W-1:0] q);
		logic [W:0] s;
		s = {1'b0, u} + {1'b0, v};
		if (s >= {1'b0, q}) begin
			s = s - {1'b0, q};
		end
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] sub_m(input logic [W-1:0] u, input logic [W-1:0] v,
	                                       input logic [W-1:0] q);
		return (u >= v) ? (u - v) : (u + (q - v));
	endfunction

	logic [2:0]                 mode_s [MERGE_STAGES-1];
	logic [N_COMP-1:0][W-1:0]   lin_s  [MERGE_STAGES-1];
	logic [N_LANES-1:0][W-1:0]  m_s    [MERGE_STAGES-1];
	logic [W-1:0]               u_s1, u_s2, u_s3, u_s4;
	logic [W-1:0]               h2_s1, k2_s1;
	logic [N_COMP-1:0][W-1:0]   sq_s2, sq_s3, sq_s4, sq_s5;
	logic [N_COMP-1:0][W-1:0]   t_s5;
	logic [N_COMP-1:0][W-1:0]   res_s6, fin_nx;

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s[0] <= mode;
			lin_s[0]  <= lin;
			m_s[0]    <= m;
			for (int j = 1; j < MERGE_STAGES-1; j++) begin
				mode_s[j] <= mode_s[j-1];
				lin_s[j]  <= lin_s[j-1];
				m_s[j]    <= m_s[j-1];
			end
			// s1: u starts, square doubles
			u_s1  <= sub_m(m[4], m[0], p);
			h2_s1 <= add_m(m[0], m[0], p);
			k2_s1 <= add_m(m[1], m[1], p);
			// s2
			u_s2     <= sub_m(u_s1, m_s[0][1], p);
			sq_s2[0] <= sub_m(h2_s1, m_s[0][2], p);
			sq_s2[1] <= sub_m(k2_s1, m_s[0][3], p);
			sq_s2[2] <= sub_m(k2_s1, m_s[0][4], p);
			sq_s2[3] <= sub_m(h2_s1, m_s[0][5], p);
			// s3, s4
			u_s3  <= add_m(u_s2, m_s[1][2], p);
			sq_s3 <= sq_s2;
			u_s4  <= add_m(u_s3, m_s[2][3], p);
			sq_s4 <= sq_s3;
			// s5
			t_s5[0] <= sub_m(u_s4, m_s[3][0], p);
			t_s5[1] <= sub_m(u_s4, m_s[3][3], p);
			t_s5[2] <= sub_m(u_s4, m_s[3][2], p);
			t_s5[3] <= sub_m(u_s4, m_s[3][1], p);
			sq_s5   <= sq_s4;
			// s6
			res_s6  <= fin_nx;
		end
	end

	always_comb begin
		fin_nx = '0;
		if (p != '0) begin
			case (mode_s[MERGE_STAGES-2])
				MODE_MUL: begin
					for (int i = 0; i < N_COMP; i++) begin
						fin_nx[i] = sub_m(t_s5[i], m_s[MERGE_STAGES-2][5+i], p);
					end
				end
				MODE_SQR: fin_nx = sq_s5;
				default:  fin_nx = lin_s[MERGE_STAGES-2];
			endcase
		end
	end

	assign res = res_s6;

endmodule

// ===== rtl/core/fcva_checker.sv =====
// Port-level checker for the Fp4 cyclic vector ALU, bound to the top level.
module fcva_checker
	import fcva_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input fcva_out_t out_data,
	input logic      pready
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// input backpressure only while a result sits unaccepted
	a_ready_low_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with empty output");

	// full skid stays full until the output drains
	a_skid_stays: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && !out_ready |=> !in_ready)
		else $error("skid emptied without an output transfer");

	// skid drains on an output transfer
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_ready |=> in_ready && out_valid)
		else $error("skid did not drain");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind fp4_cyclic_vector_alu fcva_checker u_fcva_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data),
	.pready(pready)
);
